/* hw/rtl/dtm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DFA matcher package
// Shared field widths, item kinds, status codes and the stored record types
// of the table-driven automaton matcher.
// ----------------------------------------------------------------------------
package dtm_pkg;

    localparam int ACT_W       = 2;
    localparam int STATE_W     = 6;
    localparam int SYM_W       = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_FINAL  = 2'd1,
        ACT_SYMBOL = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_ACCEPTED      = 2'd0,
        ST_NOT_FINAL     = 2'd1,
        ST_NO_TRANSITION = 2'd2
    } status_t;

    // One result as it leaves the block: status in the low bits.
    typedef struct packed {
        logic    accepted;
        status_t status;
    } result_t;

    // One transition table entry.
    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] target;
    } entry_t;

endpackage

/* hw/rtl/dtm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered and a read
// of the entry being written returns the old contents.
// ----------------------------------------------------------------------------
module dtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/dtm_result_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// A small register FIFO that holds finished results until the downstream
// side takes them, and reports its fill level for flow control.
// ----------------------------------------------------------------------------
module dtm_result_fifo #(
    parameter int DEPTH = 4,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dtm_pkg::result_t push_data,
    input  logic             pop,
    output logic             out_valid,
    output dtm_pkg::result_t out_data,
    output logic [CW-1:0]    count
);

    import dtm_pkg::*;

    result_t       mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign count     = count_reg;
    assign do_pop    = pop && out_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/dfa_transition_table_matcher_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DFA transition table matcher
// Table-driven automaton: transitions and final marks live in synchronous
// memories, strings are walked one symbol per request.
// ----------------------------------------------------------------------------
// A result passes through stage 1, stage 2 and the result queue to the output.
// Throughput: one request per cycle while s_axis_tready is high; the table
// read for a symbol takes its address straight from the previous symbol's
// table read data. Reset: asynchronous, active low. Afterwards a clearing pass
// wipes the transition table and final marks; s_axis_tready stays low.
// ----------------------------------------------------------------------------
module dfa_transition_table_matcher_core #(
    parameter int NUM_STATES = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Requests. tdata from bit 0: state_id[5:0], symbol[13:6],
    // target_state[19:14], final_flag[20], zero fill[23:21].
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [dtm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser from bit 0: action[1:0].
    input  logic [dtm_pkg::ACT_W-1:0]        s_axis_tuser,
    // tlast: last_symbol.
    input  logic                             s_axis_tlast,
    // Results. tdata from bit 0: status[1:0], accepted[2], zero fill[7:3].
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [dtm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // Start state register write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dtm_pkg::STATE_W-1:0]      cfg_data
);

    import dtm_pkg::*;

    localparam int SAW        = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int TAW        = SAW + SYM_W;
    localparam int TBL_DEPTH  = NUM_STATES * (1 << SYM_W);
    localparam int FIFO_DEPTH = 4;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Maps a state number onto the row index of the memories.
    function automatic logic [SAW-1:0] state_index(input logic [STATE_W-1:0] s);
        logic [SAW+STATE_W-1:0] wide;
        wide = {{SAW{1'b0}}, s};
        return wide[SAW-1:0];
    endfunction

    // True when the state number names a state that exists.
    function automatic logic state_ok(input logic [STATE_W-1:0] s);
        return (32'(s) < NUM_STATES);
    endfunction

    // ------------------------------------------------------------------
    // Request fields
    // ------------------------------------------------------------------
    action_t              in_act;
    logic [STATE_W-1:0]   in_sid;
    logic [SYM_W-1:0]     in_sym;
    logic [STATE_W-1:0]   in_tgt;
    logic                 in_flag;
    logic                 accept;

    assign in_act  = action_t'(s_axis_tuser);
    assign in_sid  = s_axis_tdata[5:0];
    assign in_sym  = s_axis_tdata[13:6];
    assign in_tgt  = s_axis_tdata[19:14];
    assign in_flag = s_axis_tdata[20];
    assign accept  = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [STATE_W-1:0] start_state_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg <= '0;
        end
        else if (cfg_valid)
        begin
            start_state_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Clearing pass after reset. It walks every table entry once and the
    // final marks alongside; no request is taken until it has finished.
    // ------------------------------------------------------------------
    logic [TAW-1:0] clr_cnt_reg;
    logic           clearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == TAW'(TBL_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 registers: the request whose table read data is now on the
    // memory output.
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    action_t            s1_act_reg;
    logic [STATE_W-1:0] s1_state_reg;
    logic               s1_dead_in_reg;
    logic               s1_ok_reg;
    logic               s1_last_reg;
    logic               s1_flag_reg;
    logic [STATE_W-1:0] s1_tgt_reg;
    logic [TAW-1:0]     s1_addr_reg;
    logic               s1_fwd_hit_reg;
    entry_t             s1_fwd_data_reg;

    // String tracking state, updated as each symbol leaves stage 1.
    logic [STATE_W-1:0] cur_state_reg;
    logic               dead_reg;
    logic               in_string_reg;

    entry_t             tbl_rdata;
    entry_t             entry;
    logic               s1_is_sym;
    logic               s1_dead_out;
    logic [STATE_W-1:0] s1_state_out;
    logic               s1_res;

    // The table read of stage 1 may have raced with the write of the add
    // ahead of it; the forwarded entry then stands in for the memory data.
    assign entry       = s1_fwd_hit_reg ? s1_fwd_data_reg : tbl_rdata;
    assign s1_is_sym   = s1_valid_reg && (s1_act_reg == ACT_SYMBOL);
    assign s1_dead_out = s1_dead_in_reg || !s1_ok_reg || !entry.valid;
    assign s1_state_out = s1_dead_out ? s1_state_reg : entry.target;
    assign s1_res      = s1_valid_reg &&
                         ((s1_act_reg == ACT_QUERY) ||
                          ((s1_act_reg == ACT_SYMBOL) && s1_last_reg));

    // ------------------------------------------------------------------
    // Stage 0: the request being taken this cycle. A symbol that directly
    // follows another symbol picks up the state that stage 1 is producing
    // now: one symbol per cycle while s_axis_tready is high, with no interlock.
    // ------------------------------------------------------------------
    logic [STATE_W-1:0] cur_view;
    logic               dead_view;
    logic               in_str_view;
    logic [STATE_W-1:0] sym_state;
    logic               sym_dead;
    logic [STATE_W-1:0] s0_state;
    logic               s0_ok;
    logic [TAW-1:0]     rd_addr;

    assign cur_view    = s1_is_sym ? s1_state_out : cur_state_reg;
    assign dead_view   = s1_is_sym ? s1_dead_out : dead_reg;
    assign in_str_view = s1_is_sym ? !s1_last_reg : in_string_reg;

    // The first symbol of a string begins at the start state, alive.
    assign sym_state = in_str_view ? cur_view : start_state_reg;
    assign sym_dead  = in_str_view && dead_view;

    always_comb
    begin
        case (in_act)
            ACT_ADD:
            begin
                s0_state = in_sid;
                s0_ok    = state_ok(in_sid) && state_ok(in_tgt);
            end
            ACT_FINAL:
            begin
                s0_state = in_sid;
                s0_ok    = state_ok(in_sid);
            end
            ACT_SYMBOL:
            begin
                s0_state = sym_state;
                s0_ok    = state_ok(sym_state);
            end
            ACT_QUERY:
            begin
                s0_state = start_state_reg;
                s0_ok    = state_ok(start_state_reg);
            end
            default:
            begin
                s0_state = in_sid;
                s0_ok    = 1'b0;
            end
        endcase
    end

    assign rd_addr = {state_index(s0_state), in_sym};

    // ------------------------------------------------------------------
    // Transition table: read in stage 0, checked and written in stage 1.
    // An add only writes an entry that is still empty, so the first
    // transition given for a pair is the one kept.
    // ------------------------------------------------------------------
    logic           we_add;
    entry_t         add_data;
    logic           tbl_we;
    logic [TAW-1:0] tbl_waddr;
    entry_t         tbl_wdata;
    logic           fwd_hit_next;

    assign we_add   = !clearing_reg && s1_valid_reg && (s1_act_reg == ACT_ADD) &&
                      s1_ok_reg && !entry.valid;
    assign add_data = '{valid: 1'b1, target: s1_tgt_reg};

    assign tbl_we    = clearing_reg || we_add;
    assign tbl_waddr = clearing_reg ? clr_cnt_reg : s1_addr_reg;
    assign tbl_wdata = clearing_reg ? entry_t'('0) : add_data;

    assign fwd_hit_next = we_add && (rd_addr == s1_addr_reg);

    dtm_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (rd_addr),
        .rdata (tbl_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            cur_state_reg <= '0;
            dead_reg      <= 1'b0;
            in_string_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (s1_is_sym)
            begin
                cur_state_reg <= s1_state_out;
                dead_reg      <= s1_dead_out;
                in_string_reg <= !s1_last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_act_reg      <= in_act;
        s1_state_reg    <= s0_state;
        s1_dead_in_reg  <= sym_dead;
        s1_ok_reg       <= s0_ok;
        s1_last_reg     <= s_axis_tlast;
        s1_flag_reg     <= in_flag;
        s1_tgt_reg      <= in_tgt;
        s1_addr_reg     <= rd_addr;
        s1_fwd_hit_reg  <= fwd_hit_next;
        s1_fwd_data_reg <= add_data;
    end

    // ------------------------------------------------------------------
    // Final marks: every access happens in stage 1, one request at a time,
    // so a mark written by one request is seen by the next one.
    // ------------------------------------------------------------------
    logic           fm_we;
    logic [SAW-1:0] fm_waddr;
    logic           fm_wdata;
    logic [SAW-1:0] fm_raddr;
    logic           fm_rdata;

    always_comb
    begin
        if (clearing_reg)
        begin
            fm_we    = (32'(clr_cnt_reg) < NUM_STATES);
            fm_waddr = clr_cnt_reg[SAW-1:0];
            fm_wdata = 1'b0;
        end
        else
        begin
            fm_we    = s1_valid_reg && (s1_act_reg == ACT_FINAL) && s1_ok_reg;
            fm_waddr = state_index(s1_state_reg);
            fm_wdata = s1_flag_reg;
        end
    end

    // A query reads the start state's mark; a closing symbol reads the mark
    // of the state it has just moved to.
    assign fm_raddr = state_index((s1_act_reg == ACT_QUERY) ? s1_state_reg : s1_state_out);

    dtm_ram #(
        .WIDTH (1),
        .DEPTH (NUM_STATES)
    ) u_fm_ram (
        .clk   (clk),
        .we    (fm_we),
        .waddr (fm_waddr),
        .wdata (fm_wdata),
        .raddr (fm_raddr),
        .rdata (fm_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 2: the final mark is available; form the status.
    // ------------------------------------------------------------------
    logic    s2_res_reg;
    logic    s2_dead_reg;
    logic    s2_ok_reg;
    result_t s2_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_res_reg <= 1'b0;
        end
        else
        begin
            s2_res_reg <= s1_res;
        end
    end

    // A string that is still alive ended in a state reached by a stored
    // transition, which always names an existing state.
    always_ff @(posedge clk)
    begin
        s2_dead_reg <= (s1_act_reg == ACT_SYMBOL) && s1_dead_out;
        s2_ok_reg   <= (s1_act_reg == ACT_QUERY) ? s1_ok_reg : 1'b1;
    end

    always_comb
    begin
        if (s2_dead_reg)
        begin
            s2_result.status = ST_NO_TRANSITION;
        end
        else if (s2_ok_reg && fm_rdata)
        begin
            s2_result.status = ST_ACCEPTED;
        end
        else
        begin
            s2_result.status = ST_NOT_FINAL;
        end
        s2_result.accepted = (s2_result.status == ST_ACCEPTED);
    end

    // ------------------------------------------------------------------
    // Result queue and flow control. A request is taken only while the
    // queue has room for every result that may still be on its way, so
    // the pipeline never has to stall once a request is inside.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] fifo_count;
    result_t          fifo_data;
    logic [CNT_W:0]   pending;

    dtm_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_res_reg),
        .push_data (s2_result),
        .pop       (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (fifo_data),
        .count     (fifo_count)
    );

    assign pending = (CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(s1_res) +
                     (CNT_W + 1)'(s2_res_reg);

    assign s_axis_tready = !clearing_reg && (pending < (CNT_W + 1)'(FIFO_DEPTH));

    assign m_axis_tdata = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, fifo_data};

endmodule

/* bench/tb_dfa_transition_table_matcher_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DFA transition table matcher testbench
// Drives add, final mark, symbol and empty string query requests into the
// matcher. Results are checked against the typed-in status of a directed row
// or an automaton predictor kept in step with the accepted requests. A short
// directed table comes first, then random phases, each with a new start state.
// ----------------------------------------------------------------------------
module tb_dfa_transition_table_matcher_core;

    import dtm_pkg::*;

    localparam int NSTATES      = 64;
    localparam int NSYMS        = 256;
    localparam int NUM_DIR      = 24;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 150;
    localparam int MAX_GAP      = 14;
    // Cycles to let pass after the last expected result, so that requests
    // that yield no result also leave the block before the run ends.
    localparam int TAIL_CYCLES  = 16;
    localparam int LONG_HOLD    = 400;
    localparam int MAX_REPORTS  = 10;
    // Clearing pass over 16384 entries plus about 1000 requests, each of which
    // may wait out the full sender gap and receiver stall, taken many times.
    localparam int CYCLE_LIMIT  = 600000;

    // One request as the predictor sees it.
    typedef struct packed {
        action_t            act;
        logic [STATE_W-1:0] sid;
        logic [SYM_W-1:0]   sym;
        logic [STATE_W-1:0] tgt;
        logic               flag;
        logic               last;
    } req_t;

    // One row of the directed table. Where has_exp is set, the expected
    // status is typed in; otherwise the predictor supplies it.
    typedef struct {
        req_t    req;
        bit      has_exp;
        status_t exp_status;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [ACT_W-1:0]       s_axis_tuser = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [STATE_W-1:0]     cfg_data = '0;

    // Predicted automaton: transition table, final marks and the string walk.
    bit                     tbl_valid [0:NSTATES*NSYMS-1];
    bit [STATE_W-1:0]       tbl_target [0:NSTATES*NSYMS-1];
    bit                     final_mark [0:NSTATES-1];
    bit [STATE_W-1:0]       walk_state;
    bit                     walk_dead;
    bit                     walk_active;
    bit [STATE_W-1:0]       start_reg;

    // Verdicts still owed by the block, oldest first.
    result_t                pending_verdicts [$];

    int                     error_count;
    int                     cycle_count;
    bit                     sender_burst;
    bit                     receiver_burst;
    bit                     long_hold_req;
    int                     hold_len;
    result_t                seen_verdict;
    result_t                due_verdict;

    dfa_transition_table_matcher_core #(
        .NUM_STATES(NSTATES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Status of a string that stopped in state s, or died on the way.
    function automatic result_t verdict(input bit dead, input bit [STATE_W-1:0] s);
        result_t v;
        if (dead)
            v.status = ST_NO_TRANSITION;
        else if (final_mark[s])
            v.status = ST_ACCEPTED;
        else
            v.status = ST_NOT_FINAL;
        v.accepted = (v.status == ST_ACCEPTED);
        return v;
    endfunction

    // Applies one accepted request to the predicted automaton. Returns 1 when
    // the request yields a result, which is then placed in res.
    function automatic bit automaton_step(input req_t r, output result_t res);
        int idx;
        res = verdict(1'b1, '0);
        case (r.act)
            ACT_ADD:
            begin
                // The first transition written for a pair is the one kept.
                idx = int'({r.sid, r.sym});
                if (!tbl_valid[idx])
                begin
                    tbl_valid[idx]  = 1'b1;
                    tbl_target[idx] = r.tgt;
                end
                return 1'b0;
            end
            ACT_FINAL:
            begin
                final_mark[r.sid] = r.flag;
                return 1'b0;
            end
            ACT_QUERY:
            begin
                // The empty string ends where it begins; the walk is untouched.
                res = verdict(1'b0, start_reg);
                return 1'b1;
            end
            default:
            begin
                if (!walk_active)
                begin
                    walk_state  = start_reg;
                    walk_dead   = 1'b0;
                    walk_active = 1'b1;
                end
                if (!walk_dead)
                begin
                    idx = int'({walk_state, r.sym});
                    if (tbl_valid[idx])
                        walk_state = tbl_target[idx];
                    else
                        walk_dead = 1'b1;
                end
                if (r.last)
                begin
                    res = verdict(walk_dead, walk_state);
                    walk_active = 1'b0;
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Offers one request after a random gap and waits for the handshake. The
    // predictor is advanced at the edge where the request is taken. Entered
    // and left at a falling edge; tvalid stays high on return so that a
    // back-to-back request needs no second assignment in the same step.
    task automatic push_request(input req_t r, input bit fixed, input result_t fixed_res);
        int      gap;
        result_t v;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, r.flag, r.tgt, r.sym, r.sid};
        s_axis_tuser  <= r.act;
        s_axis_tlast  <= r.last;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        if (automaton_step(r, v))
            pending_verdicts.push_back(fixed ? fixed_res : v);
        @(negedge clk);
    endtask

    // Writes the start state once the block has drained.
    task automatic write_start_state(input bit [STATE_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        start_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls, bursts with none, and one long hold-off on
    // request from the stimulus so that the block backs up into its input.
    initial
    begin
        @(negedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_len = LONG_HOLD;
            end
            else
                hold_len = receiver_burst ? 0 : $urandom_range(0, MAX_GAP);
            repeat (hold_len)
            begin
                m_axis_tready <= 1'b0;
                @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
            @(negedge clk);
        end
    end

    // Each result taken is compared with the oldest verdict still owed.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_verdict = result_t'(m_axis_tdata[2:0]);
            if (pending_verdicts.size() == 0)
                flag_error($sformatf("%0t: result status=%0d accepted=%0b with none pending",
                                     $realtime, seen_verdict.status, seen_verdict.accepted));
            else
            begin
                due_verdict = pending_verdicts.pop_front();
                if (seen_verdict.status !== due_verdict.status)
                    flag_error($sformatf("%0t: status expected %0d got %0d", $realtime,
                                         due_verdict.status, seen_verdict.status));
                if (seen_verdict.accepted !== due_verdict.accepted)
                    flag_error($sformatf("%0t: accepted expected %0b got %0b", $realtime,
                                         due_verdict.accepted, seen_verdict.accepted));
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        dir_row_t         dir_rows [NUM_DIR];
        result_t          fixed_res;
        result_t          unused_res;
        req_t             q;
        bit [STATE_W-1:0] pool [8];
        bit [SYM_W-1:0]   alpha [4];
        bit [SYM_W-1:0]   cands [4];
        bit [STATE_W-1:0] walk_from;
        bit [STATE_W-1:0] start_v;
        int               n;
        int               r;
        int               cand_cnt;
        int               str_left;

        // Directed requests, starting from the reset start state of zero.
        dir_rows = '{
            // Straight after reset nothing is final and the table is empty.
            '{'{ACT_QUERY,  6'd0,  8'h00, 6'd0,  1'b0, 1'b0}, 1'b1, ST_NOT_FINAL},
            '{'{ACT_SYMBOL, 6'd0,  8'h00, 6'd0,  1'b0, 1'b1}, 1'b1, ST_NO_TRANSITION},
            // Symbol zero is an ordinary label; the second add is a duplicate.
            '{'{ACT_ADD,    6'd0,  8'h00, 6'd1,  1'b0, 1'b0}, 1'b0, ST_ACCEPTED},
            '{'{ACT_ADD,    6'd0,  8'h00, 6'd2,  1'b0, 1'b0}, 1'b0, ST_ACCEPTED},
            '{'{ACT_ADD,    6'd1,  8'hFF, 6'd63, 1'b1, 1'b1}, 1'b0, ST_ACCEPTED},
            '{'{ACT_FINAL,  6'd63, 8'h00, 6'd0,  1'b1, 1'b0}, 1'b0, ST_ACCEPTED},
            '{'{ACT_SYMBOL, 6'd0,  8'h00, 6'd0,  1'b0, 1'b0}, 1'b0, ST_ACCEPTED},
            '{'{ACT_SYMBOL, 6'd0,  8'hFF, 6'd0,  1'b0, 1'b1}, 1'b0, ST_ACCEPTED},
            // Clearing the mark turns the same string into a non-final one.
            '{'{ACT_FINAL,  6'd63, 8'h00, 6'd0,  1'b0, 1'b1}, 1'b0, ST_ACCEPTED},
            '{'{ACT_SYMBOL, 6'd0,  8'h00, 6'd0,  1'b0, 1'b0}, 1'b0, ST_ACCEPTED},
            '{'{ACT_SYMBOL, 6'd0,  8'hFF, 6'd0,  1'b0, 1'b1}, 1'b0, ST_ACCEPTED},
            '{'{ACT_FINAL,  6'd0,  8'h00, 6'd0,  1'b1, 1'b0}, 1'b0, ST_ACCEPTED},
            '{'{ACT_QUERY,  6'd0,  8'h00, 6'd0,  1'b0, 1'b0}, 1'b1, ST_ACCEPTED},
            '{'{ACT_SYMBOL, 6'd0,  8'h55, 6'd0,  1'b0, 1'b1}, 1'b1, ST_NO_TRANSITION},
            // A dead string ignores the rest of its symbols.
            '{'{ACT_SYMBOL, 6'd0,  8'h33, 6'd0,  1'b0, 1'b0}, 1'b0, ST_ACCEPTED},
            '{'{ACT_SYMBOL, 6'd0,  8'h00, 6'd0,  1'b0, 1'b0}, 1'b0, ST_ACCEPTED},
            '{'{ACT_SYMBOL, 6'd0,  8'h00, 6'd0,  1'b0, 1'b1}, 1'b1, ST_NO_TRANSITION},
            // Table changes and a query in the middle of a string.
            '{'{ACT_SYMBOL, 6'd0,  8'h00, 6'd0,  1'b0, 1'b0}, 1'b0, ST_ACCEPTED},
            '{'{ACT_ADD,    6'd1,  8'h80, 6'd0,  1'b0, 1'b0}, 1'b0, ST_ACCEPTED},
            '{'{ACT_QUERY,  6'd0,  8'h00, 6'd0,  1'b0, 1'b0}, 1'b1, ST_ACCEPTED},
            '{'{ACT_SYMBOL, 6'd0,  8'h80, 6'd0,  1'b0, 1'b1}, 1'b0, ST_ACCEPTED},
            '{'{ACT_ADD,    6'd63, 8'hFF, 6'd63, 1'b1, 1'b1}, 1'b0, ST_ACCEPTED},
            '{'{ACT_ADD,    6'd63, 8'h00, 6'd0,  1'b0, 1'b0}, 1'b0, ST_ACCEPTED},
            // Left open, so the start state is rewritten mid-string below.
            '{'{ACT_SYMBOL, 6'd0,  8'h00, 6'd0,  1'b0, 1'b0}, 1'b0, ST_ACCEPTED}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The first request waits out the clearing pass on tready.
        for (int i = 0; i < NUM_DIR; i++)
        begin
            fixed_res.status   = dir_rows[i].exp_status;
            fixed_res.accepted = (dir_rows[i].exp_status == ST_ACCEPTED);
            push_request(dir_rows[i].req, dir_rows[i].has_exp, fixed_res);
        end

        str_left = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 0)
                start_v = 6'd63;
            else if (ph == 1)
                start_v = 6'd0;
            else
                start_v = STATE_W'($urandom_range(0, NSTATES - 1));
            write_start_state(start_v);

            // Each phase works on a small cluster of states and a few symbols
            // so that strings get past the first transitions.
            pool[0] = start_v;
            for (int k = 1; k < 8; k++)
                pool[k] = STATE_W'($urandom_range(0, NSTATES - 1));
            foreach (alpha[k])
                alpha[k] = SYM_W'($urandom_range(0, NSYMS - 1));
            if (ph == 0)
            begin
                alpha[0] = 8'h00;
                alpha[3] = 8'hFF;
            end
            sender_burst   = (ph == 2) || (ph == 4);
            receiver_burst = (ph == 3);
            long_hold_req  = (ph == 2);

            n = 0;
            while (n < PHASE_ITEMS)
            begin
                // Default is a fully random request, used as noise.
                q.act  = action_t'($urandom_range(0, 3));
                q.sid  = STATE_W'($urandom_range(0, NSTATES - 1));
                q.sym  = SYM_W'($urandom_range(0, NSYMS - 1));
                q.tgt  = STATE_W'($urandom_range(0, NSTATES - 1));
                q.flag = 1'($urandom_range(0, 1));
                q.last = 1'($urandom_range(0, 1));
                r = $urandom_range(0, 99);
                if ((n < 24 && r < 70) || (r >= 10 && r < 25))
                begin
                    q.act = ACT_ADD;
                    q.sid = pool[$urandom_range(0, 7)];
                    q.sym = alpha[$urandom_range(0, 3)];
                    q.tgt = pool[$urandom_range(0, 7)];
                end
                else if (r < 10)
                begin
                end
                else if (r < 32)
                begin
                    q.act  = ACT_FINAL;
                    q.sid  = pool[$urandom_range(0, 7)];
                    q.flag = ($urandom_range(0, 9) < 7);
                end
                else if (r < 37)
                    q.act = ACT_QUERY;
                else
                begin
                    // A symbol of a string of 1 to 8 symbols, mostly one that
                    // follows an existing transition from where the walk is.
                    q.act = ACT_SYMBOL;
                    if (!walk_active || str_left < 1)
                        str_left = $urandom_range(1, 8);
                    walk_from = walk_active ? walk_state : start_reg;
                    cand_cnt = 0;
                    foreach (alpha[k])
                    begin
                        if (tbl_valid[{walk_from, alpha[k]}])
                        begin
                            cands[cand_cnt] = alpha[k];
                            cand_cnt++;
                        end
                    end
                    if (cand_cnt > 0 && $urandom_range(0, 99) < 85)
                        q.sym = cands[$urandom_range(0, cand_cnt - 1)];
                    else if ($urandom_range(0, 1) == 1)
                        q.sym = alpha[$urandom_range(0, 3)];
                    q.last = (str_left == 1);
                    str_left--;
                end
                push_request(q, 1'b0, unused_res);
                n++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
